[src/mcc_pkg.sv]
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants of the motor command codec
// Field ranges, code widths, fixed-point scales, reciprocal constants for the
// constant divisions, and the handshake payload types.
// ----------------------------------------------------------------------------
package mcc_pkg;

  // Code widths of the command fields
  localparam int POSITION_BITS = 16;
  localparam int FIELD_BITS    = 12;
  localparam int CODE_W        = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;
  localparam int MIN_BITS      = (POSITION_BITS < FIELD_BITS) ? POSITION_BITS : FIELD_BITS;
  localparam int POS_D         = (1 << POSITION_BITS) - 1;
  localparam int FLD_D         = (1 << FIELD_BITS) - 1;

  // Q16.16 values
  localparam int Q_FRAC  = 16;
  localparam int VALUE_W = 32;

  // Full span of each field in whole units (span = units * 2^Q_FRAC)
  localparam int POS_UNITS = 25;
  localparam int VEL_UNITS = 100;
  localparam int KP_UNITS  = 500;
  localparam int KD_UNITS  = 5;
  localparam int TOR_UNITS = 50;

  localparam int POS_LO = -((POS_UNITS << Q_FRAC) / 2);
  localparam int VEL_LO = -((VEL_UNITS << Q_FRAC) / 2);
  localparam int KP_LO  = 0;
  localparam int KD_LO  = 0;
  localparam int TOR_LO = -((TOR_UNITS << Q_FRAC) / 2);

  localparam int POS_HI = POS_LO + (POS_UNITS << Q_FRAC);
  localparam int VEL_HI = VEL_LO + (VEL_UNITS << Q_FRAC);
  localparam int KP_HI  = KP_LO + (KP_UNITS << Q_FRAC);
  localparam int KD_HI  = KD_LO + (KD_UNITS << Q_FRAC);
  localparam int TOR_HI = TOR_LO + (TOR_UNITS << Q_FRAC);

  // Codes of 0.0 (symmetric fields sit at the middle, gains at the bottom)
  localparam int POS_ZERO_CODE = POS_D / 2;
  localparam int VEL_ZERO_CODE = FLD_D / 2;
  localparam int KP_ZERO_CODE  = 0;
  localparam int KD_ZERO_CODE  = 0;
  localparam int TOR_ZERO_CODE = FLD_D / 2;

  // Encoder: offset, scaled numerator and reciprocal of the unit count
  localparam int OFF_W       = $clog2((KP_UNITS << Q_FRAC) + 1);
  localparam int ENC_PROD_W  = OFF_W + CODE_W;
  localparam int N_MAX_POS   = POS_UNITS * POS_D;
  localparam int N_MAX_FLD   = KP_UNITS * FLD_D;
  localparam int N_MAX       = (N_MAX_POS > N_MAX_FLD) ? N_MAX_POS : N_MAX_FLD;
  localparam int N_W         = $clog2(N_MAX + 1);
  localparam int ENC_K       = 31;
  localparam longint ENC_REC_POS = ((longint'(1) << ENC_K) + POS_UNITS - 1) / POS_UNITS;
  localparam longint ENC_REC_VEL = ((longint'(1) << ENC_K) + VEL_UNITS - 1) / VEL_UNITS;
  localparam longint ENC_REC_KP  = ((longint'(1) << ENC_K) + KP_UNITS - 1) / KP_UNITS;
  localparam longint ENC_REC_KD  = ((longint'(1) << ENC_K) + KD_UNITS - 1) / KD_UNITS;
  localparam longint ENC_REC_TOR = ((longint'(1) << ENC_K) + TOR_UNITS - 1) / TOR_UNITS;
  localparam int ENC_REC_W   = $clog2(ENC_REC_KD + 1);
  localparam int ENC_MUL_W   = N_W + ENC_REC_W;

  // Decoder: base term, rounding numerator and reciprocal of 2^bits - 1
  localparam int DEC_LANES    = 3;
  localparam int BASE_MAX_POS = (POS_UNITS * POS_D) << (Q_FRAC - POSITION_BITS);
  localparam int BASE_MAX_VEL = (VEL_UNITS * FLD_D) << (Q_FRAC - FIELD_BITS);
  localparam int BASE_MAX     = (BASE_MAX_POS > BASE_MAX_VEL) ? BASE_MAX_POS : BASE_MAX_VEL;
  localparam int BASE_W       = $clog2(BASE_MAX + 1);
  localparam int HALF_MAX     = ((POS_D > FLD_D) ? POS_D : FLD_D) / 2;
  localparam int Y_W          = $clog2(BASE_MAX + HALF_MAX + 1);
  localparam int T_W          = Y_W - MIN_BITS + 1;
  localparam int DEC_K        = 40;
  localparam longint DEC_REC_POS = ((longint'(1) << DEC_K) + POS_D - 1) / POS_D;
  localparam longint DEC_REC_FLD = ((longint'(1) << DEC_K) + FLD_D - 1) / FLD_D;
  localparam longint DEC_REC_MAX = (DEC_REC_POS > DEC_REC_FLD) ? DEC_REC_POS : DEC_REC_FLD;
  localparam int DEC_REC_W    = $clog2(DEC_REC_MAX + 1);
  localparam int DEC_MUL_W    = Y_W + DEC_REC_W;
  localparam int DEC_R_W      = BASE_W + 2;

  // Frame layout
  localparam int FRAME_BYTES   = 8;
  localparam int FRAME_W       = 8 * FRAME_BYTES;
  localparam int FRAME_POS_W   = 16;
  localparam int FRAME_FLD_W   = 12;
  localparam int REPLY_W       = FRAME_POS_W + 2 * FRAME_FLD_W;
  localparam logic [7:0] FILL_BYTE      = 8'hFF;
  localparam logic [7:0] MODE_BYTE_BASE = 8'hFC;

  // Reading widths
  localparam int RD_POS_W = 21;
  localparam int RD_VEL_W = 23;
  localparam int RD_TOR_W = 22;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWERED  = 1'd1;

  // Output queue
  localparam int OUT_FIFO_DEPTH = 4;
  localparam int PTR_W          = $clog2(OUT_FIFO_DEPTH);
  localparam int COUNT_W        = $clog2(OUT_FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_SET   = 2'd0,
    KIND_SEND  = 2'd1,
    KIND_MODE  = 2'd2,
    KIND_REPLY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    FLD_POS = 3'd0,
    FLD_VEL = 3'd1,
    FLD_KP  = 3'd2,
    FLD_KD  = 3'd3,
    FLD_TOR = 3'd4
  } field_e;

  typedef enum logic [1:0] {
    MODE_ENTER = 2'd0,
    MODE_EXIT  = 2'd1,
    MODE_ZERO  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RES_CMD  = 2'd0,
    RES_MODE = 2'd1,
    RES_READ = 2'd2
  } res_kind_e;

  typedef struct packed {
    res_kind_e                   result_kind;
    logic [7:0]                  frame_id;
    logic [FRAME_W-1:0]          frame_bytes;
    logic signed [RD_POS_W-1:0]  read_position;
    logic signed [RD_VEL_W-1:0]  read_velocity;
    logic signed [RD_TOR_W-1:0]  read_torque;
    logic                        last;
  } mcc_res_t;

  // Lower clamp bound of a field
  function automatic logic signed [VALUE_W-1:0] field_lo(input logic [2:0] f);
    logic signed [VALUE_W-1:0] r;
    unique case (f)
      FLD_POS: r = VALUE_W'(POS_LO);
      FLD_VEL: r = VALUE_W'(VEL_LO);
      FLD_KP:  r = VALUE_W'(KP_LO);
      FLD_KD:  r = VALUE_W'(KD_LO);
      default: r = VALUE_W'(TOR_LO);
    endcase
    return r;
  endfunction

  // Upper clamp bound of a field
  function automatic logic signed [VALUE_W-1:0] field_hi(input logic [2:0] f);
    logic signed [VALUE_W-1:0] r;
    unique case (f)
      FLD_POS: r = VALUE_W'(POS_HI);
      FLD_VEL: r = VALUE_W'(VEL_HI);
      FLD_KP:  r = VALUE_W'(KP_HI);
      FLD_KD:  r = VALUE_W'(KD_HI);
      default: r = VALUE_W'(TOR_HI);
    endcase
    return r;
  endfunction

  // Reciprocal of the span in units, scaled by 2^ENC_K and rounded up
  function automatic logic [ENC_REC_W-1:0] enc_recip(input logic [2:0] f);
    logic [ENC_REC_W-1:0] r;
    unique case (f)
      FLD_POS: r = ENC_REC_W'(ENC_REC_POS);
      FLD_VEL: r = ENC_REC_W'(ENC_REC_VEL);
      FLD_KP:  r = ENC_REC_W'(ENC_REC_KP);
      FLD_KD:  r = ENC_REC_W'(ENC_REC_KD);
      default: r = ENC_REC_W'(ENC_REC_TOR);
    endcase
    return r;
  endfunction

endpackage

[src/mcc_cmd_if.sv]
// ----------------------------------------------------------------------------
// mcc_cmd_if: request channel of the motor command codec
// Valid/ready handshake carrying one command, mode or reply request.
// ----------------------------------------------------------------------------
interface mcc_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         field_index;
  logic signed [31:0] value;
  logic [1:0]         mode_code;
  logic [39:0]        reply_bytes;

  modport source (
    output valid, kind, field_index, value, mode_code, reply_bytes,
    input  ready
  );

  modport sink (
    input  valid, kind, field_index, value, mode_code, reply_bytes,
    output ready
  );
endinterface

[src/mcc_res_if.sv]
// ----------------------------------------------------------------------------
// mcc_res_if: result channel of the motor command codec
// Valid/ready handshake carrying one frame or one set of decoded readings.
// ----------------------------------------------------------------------------
interface mcc_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [7:0]         frame_id;
  logic [63:0]        frame_bytes;
  logic signed [20:0] read_position;
  logic signed [22:0] read_velocity;
  logic signed [21:0] read_torque;
  logic               last;

  modport source (
    output valid, result_kind, frame_id, frame_bytes, read_position, read_velocity,
           read_torque, last,
    input  ready
  );

  modport sink (
    input  valid, result_kind, frame_id, frame_bytes, read_position, read_velocity,
           read_torque, last,
    output ready
  );
endinterface

[src/mcc_field_encode.sv]
// ----------------------------------------------------------------------------
// mcc_field_encode: Q16.16 value to unsigned field code
// Clamps to the field range and computes floor((x - lo) * d / span) in two
// register stages: shift-subtract scaling, then a reciprocal multiply.
// ----------------------------------------------------------------------------
module mcc_field_encode import mcc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [2:0]                field_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic [CODE_W-1:0]         code_o
);

  logic signed [VALUE_W-1:0] lo;
  logic signed [VALUE_W-1:0] hi;
  logic signed [VALUE_W-1:0] x_cl;
  logic [OFF_W-1:0]          off;
  logic [ENC_PROD_W-1:0]     scaled;
  logic [N_W-1:0]            num;
  logic [N_W-1:0]            num_q;
  logic [2:0]                field_q;
  logic [ENC_MUL_W-1:0]      quot_prod;
  logic [CODE_W-1:0]         code_q;

  // Clamp and take the offset from the bottom of the range
  always_comb begin
    lo = field_lo(field_i);
    hi = field_hi(field_i);
    if (value_i < lo) begin
      x_cl = lo;
    end else if (value_i > hi) begin
      x_cl = hi;
    end else begin
      x_cl = value_i;
    end
    off = OFF_W'(x_cl - lo);
  end

  // off * (2^bits - 1), then drop the Q16.16 fraction of the span
  always_comb begin
    if (field_i == FLD_POS) begin
      scaled = (ENC_PROD_W'(off) << POSITION_BITS) - ENC_PROD_W'(off);
    end else begin
      scaled = (ENC_PROD_W'(off) << FIELD_BITS) - ENC_PROD_W'(off);
    end
    num = N_W'(scaled >> Q_FRAC);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= num;
      field_q <= field_i;
    end
  end

  // Divide by the span in whole units through its reciprocal
  assign quot_prod = ENC_MUL_W'(num_q) * ENC_MUL_W'(enc_recip(field_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code_q <= CODE_W'(quot_prod >> ENC_K);
    end
  end

  assign code_o = code_q;

endmodule

[src/mcc_reply_decode.sv]
// ----------------------------------------------------------------------------
// mcc_reply_decode: reply codes to Q16.16 readings
// Three lanes (position, velocity, torque) compute
// round_half_up(code * span / d) + lo as base + floor((base + d/2) / d) + lo,
// with base = code * units * 2^(16 - bits).
// ----------------------------------------------------------------------------
module mcc_reply_decode import mcc_pkg::*; (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [REPLY_W-1:0]                   reply_i,
  output logic [DEC_LANES-1:0][DEC_R_W-1:0]    reading_o
);

  for (genvar g = 0; g < DEC_LANES; g++) begin : g_lane
    localparam int BITS  = (g == 0) ? POSITION_BITS : FIELD_BITS;
    localparam int IN_W  = (g == 0) ? FRAME_POS_W : FRAME_FLD_W;
    localparam int LSB   = (g == 0) ? 2 * FRAME_FLD_W : ((g == 1) ? FRAME_FLD_W : 0);
    localparam int UNITS = (g == 0) ? POS_UNITS : ((g == 1) ? VEL_UNITS : TOR_UNITS);
    localparam int LO    = (g == 0) ? POS_LO : ((g == 1) ? VEL_LO : TOR_LO);
    localparam int D     = (1 << BITS) - 1;
    localparam int HALF  = D / 2;
    localparam int SH    = Q_FRAC - BITS;
    localparam longint REC = (g == 0) ? DEC_REC_POS : DEC_REC_FLD;
    localparam longint IN_MASK = (longint'(1) << IN_W) - 1;

    logic [FRAME_POS_W-1:0] raw;
    logic [FRAME_POS_W-1:0] code;
    logic [BASE_W-1:0]      base;
    logic [BASE_W-1:0]      base_b_q;
    logic [BASE_W-1:0]      base_c_q;
    logic [Y_W-1:0]         y;
    logic [DEC_MUL_W-1:0]   prod;
    logic [T_W-1:0]         t_c_q;

    // Slice the code and saturate codes above the field maximum
    assign raw  = FRAME_POS_W'((reply_i >> LSB) & REPLY_W'(IN_MASK));
    assign code = (raw > FRAME_POS_W'(D)) ? FRAME_POS_W'(D) : raw;
    assign base = (BASE_W'(code) * BASE_W'(UNITS)) << SH;

    // Rounded quotient by 2^bits - 1 through its reciprocal
    assign y    = Y_W'(base_b_q) + Y_W'(HALF);
    assign prod = DEC_MUL_W'(y) * DEC_MUL_W'(REC);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        base_b_q <= base;
        base_c_q <= base_b_q;
        t_c_q    <= T_W'(prod >> DEC_K);
      end
    end

    assign reading_o[g] = DEC_R_W'(base_c_q) + DEC_R_W'(t_c_q) + DEC_R_W'(LO);
  end

endmodule

[src/motor_can_command_codec.sv]
// ----------------------------------------------------------------------------
// motor_can_command_codec: motor command packing and reply decoding
// Holds the five command codes, builds 8-byte command and mode frames and
// unpacks reply bytes into Q16.16 readings.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle unless the pipe stalls. Each request
// passes an input register and two arithmetic stages (clamp/scale, reciprocal
// multiply), and its results, up to two, then enter a four-entry output queue.
// Command state is read and written only at the last stage, so requests see
// the effect of every earlier request. Ready drops only while the last stage
// holds a request and the output queue has fewer than two free entries.
// Configuration writes (motor_id, powered) take effect at the next edge; the
// user must make them while no request is in flight; the block itself does
// not enforce this.
module motor_can_command_codec import mcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mcc_cmd_if.sink               cmd_i,
  mcc_res_if.source             res_o
);

  // Pipeline control
  logic stall;
  logic adv;
  logic retire;
  logic pop;

  // Stage 1: input register
  logic                      s1_valid_q;
  kind_e                     s1_kind_q;
  logic [2:0]                s1_field_q;
  logic signed [VALUE_W-1:0] s1_value_q;
  logic [1:0]                s1_mode_q;
  logic [REPLY_W-1:0]        s1_reply_q;

  // Stages 2 and 3: control that travels with the arithmetic
  logic       s2_valid_q;
  kind_e      s2_kind_q;
  logic [2:0] s2_field_q;
  logic [1:0] s2_mode_q;
  logic       s3_valid_q;
  kind_e      s3_kind_q;
  logic [2:0] s3_field_q;
  logic [1:0] s3_mode_q;

  // Arithmetic units
  logic [2:0]                             enc_field;
  logic [CODE_W-1:0]                      enc_code;
  logic [DEC_LANES-1:0][DEC_R_W-1:0]      dec_reading;

  // Configuration and command state
  logic [7:0]               motor_id_q;
  logic                     powered_q;
  logic [POSITION_BITS-1:0] pos_code_q, pos_code_d;
  logic [FIELD_BITS-1:0]    vel_code_q, vel_code_d;
  logic [FIELD_BITS-1:0]    kp_code_q, kp_code_d;
  logic [FIELD_BITS-1:0]    kd_code_q, kd_code_d;
  logic [FIELD_BITS-1:0]    tor_code_q, tor_code_d;

  // Results of the last stage
  mcc_res_t   res0, res1;
  logic [1:0] push_n;

  // Output queue
  mcc_res_t           fifo_q [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [COUNT_W-1:0] count_q;

  function automatic logic [FRAME_W-1:0] pack_cmd(
    input logic [POSITION_BITS-1:0] pos,
    input logic [FIELD_BITS-1:0]    vel,
    input logic [FIELD_BITS-1:0]    kp,
    input logic [FIELD_BITS-1:0]    kd,
    input logic [FIELD_BITS-1:0]    tor
  );
    return {FRAME_POS_W'(pos), FRAME_FLD_W'(vel), FRAME_FLD_W'(kp), FRAME_FLD_W'(kd),
            FRAME_FLD_W'(tor)};
  endfunction

  function automatic mcc_res_t make_frame(
    input res_kind_e          k,
    input logic [7:0]         id,
    input logic [FRAME_W-1:0] bytes,
    input logic               last
  );
    mcc_res_t r;
    r             = '0;
    r.result_kind = k;
    r.frame_id    = id;
    r.frame_bytes = bytes;
    r.last        = last;
    return r;
  endfunction

  // Advance the whole pipe unless the last stage cannot unload
  assign stall  = s3_valid_q && (count_q > COUNT_W'(OUT_FIFO_DEPTH - 2));
  assign adv    = !stall;
  assign retire = s3_valid_q && adv;
  assign cmd_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= cmd_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q  <= kind_e'(cmd_i.kind);
      s1_field_q <= cmd_i.field_index;
      s1_value_q <= cmd_i.value;
      s1_mode_q  <= cmd_i.mode_code;
      s1_reply_q <= cmd_i.reply_bytes;
      s2_kind_q  <= s1_kind_q;
      s2_field_q <= s1_field_q;
      s2_mode_q  <= s1_mode_q;
      s3_kind_q  <= s2_kind_q;
      s3_field_q <= s2_field_q;
      s3_mode_q  <= s2_mode_q;
    end
  end

  // A send request always encodes the position
  assign enc_field = (s1_kind_q == KIND_SEND) ? FLD_POS : s1_field_q;

  mcc_field_encode u_encode (
    .clk_i   (clk_i),
    .en_i    (adv),
    .field_i (enc_field),
    .value_i (s1_value_q),
    .code_o  (enc_code)
  );

  mcc_reply_decode u_decode (
    .clk_i     (clk_i),
    .en_i      (adv),
    .reply_i   (s1_reply_q),
    .reading_o (dec_reading)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q <= '0;
      powered_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MOTOR_ID: motor_id_q <= cfg_wdata_i;
        CFG_POWERED:  powered_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Last stage: update command state and form the results
  always_comb begin
    pos_code_d = pos_code_q;
    vel_code_d = vel_code_q;
    kp_code_d  = kp_code_q;
    kd_code_d  = kd_code_q;
    tor_code_d = tor_code_q;
    res0       = '0;
    res1       = '0;
    push_n     = 2'd0;
    unique case (s3_kind_q)
      KIND_SET: begin
        unique case (s3_field_q)
          FLD_POS: pos_code_d = POSITION_BITS'(enc_code);
          FLD_VEL: vel_code_d = FIELD_BITS'(enc_code);
          FLD_KP:  kp_code_d  = FIELD_BITS'(enc_code);
          FLD_KD:  kd_code_d  = FIELD_BITS'(enc_code);
          FLD_TOR: tor_code_d = FIELD_BITS'(enc_code);
          default: ;
        endcase
      end
      KIND_SEND: begin
        if (powered_q) begin
          pos_code_d = POSITION_BITS'(enc_code);
          res0   = make_frame(RES_CMD, motor_id_q,
                              pack_cmd(pos_code_d, vel_code_q, kp_code_q, kd_code_q,
                                       tor_code_q), 1'b1);
          push_n = 2'd1;
        end
      end
      KIND_MODE: begin
        priority if (s3_mode_q == MODE_ZERO) begin
          // Clear every command; the cleared frame goes out first when powered
          pos_code_d = POSITION_BITS'(POS_ZERO_CODE);
          vel_code_d = FIELD_BITS'(VEL_ZERO_CODE);
          kp_code_d  = FIELD_BITS'(KP_ZERO_CODE);
          kd_code_d  = FIELD_BITS'(KD_ZERO_CODE);
          tor_code_d = FIELD_BITS'(TOR_ZERO_CODE);
          if (powered_q) begin
            res0   = make_frame(RES_CMD, motor_id_q,
                                pack_cmd(pos_code_d, vel_code_d, kp_code_d, kd_code_d,
                                         tor_code_d), 1'b0);
            res1   = make_frame(RES_MODE, motor_id_q,
                                {{(FRAME_BYTES - 1){FILL_BYTE}},
                                 MODE_BYTE_BASE + 8'(s3_mode_q)}, 1'b1);
            push_n = 2'd2;
          end else begin
            res0   = make_frame(RES_MODE, motor_id_q,
                                {{(FRAME_BYTES - 1){FILL_BYTE}},
                                 MODE_BYTE_BASE + 8'(s3_mode_q)}, 1'b1);
            push_n = 2'd1;
          end
        end else if (s3_mode_q == MODE_ENTER || s3_mode_q == MODE_EXIT) begin
          res0   = make_frame(RES_MODE, motor_id_q,
                              {{(FRAME_BYTES - 1){FILL_BYTE}},
                               MODE_BYTE_BASE + 8'(s3_mode_q)}, 1'b1);
          push_n = 2'd1;
        end else begin
          // Unknown mode code: drop
          push_n = 2'd0;
        end
      end
      KIND_REPLY: begin
        res0.result_kind   = RES_READ;
        res0.read_position = RD_POS_W'(dec_reading[0]);
        res0.read_velocity = RD_VEL_W'(dec_reading[1]);
        res0.read_torque   = RD_TOR_W'(dec_reading[2]);
        res0.last          = 1'b1;
        push_n             = 2'd1;
      end
    endcase
  end

  // Command state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_code_q <= POSITION_BITS'(POS_ZERO_CODE);
      vel_code_q <= FIELD_BITS'(VEL_ZERO_CODE);
      kp_code_q  <= FIELD_BITS'(KP_ZERO_CODE);
      kd_code_q  <= FIELD_BITS'(KD_ZERO_CODE);
      tor_code_q <= FIELD_BITS'(TOR_ZERO_CODE);
    end else if (retire) begin
      pos_code_q <= pos_code_d;
      vel_code_q <= vel_code_d;
      kp_code_q  <= kp_code_d;
      kd_code_q  <= kd_code_d;
      tor_code_q <= tor_code_d;
    end
  end

  // Output queue: push up to two results, pop one
  assign pop = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (retire && push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (retire && push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (retire) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + (retire ? COUNT_W'(push_n) : COUNT_W'(0)) - COUNT_W'(pop);
    end
  end

  assign res_o.valid         = (count_q != '0);
  assign res_o.result_kind   = fifo_q[rd_ptr_q].result_kind;
  assign res_o.frame_id      = fifo_q[rd_ptr_q].frame_id;
  assign res_o.frame_bytes   = fifo_q[rd_ptr_q].frame_bytes;
  assign res_o.read_position = fifo_q[rd_ptr_q].read_position;
  assign res_o.read_velocity = fifo_q[rd_ptr_q].read_velocity;
  assign res_o.read_torque   = fifo_q[rd_ptr_q].read_torque;
  assign res_o.last          = fifo_q[rd_ptr_q].last;

  // Queue never holds more than its depth
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(OUT_FIFO_DEPTH))
    else $error("output queue overflow");

  // The second result of a request is already queued when the first leaves
  a_pair_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !res_o.last) |=> res_o.valid)
    else $error("result pair split in output queue");

  // Command frames are only produced while powered
  a_cmd_powered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && push_n != 2'd0 && res0.result_kind == RES_CMD) |-> powered_q)
    else $error("command frame while unpowered");

  // Decoded position stays inside its range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.result_kind == RES_READ) |->
      (res_o.read_position >= RD_POS_W'(POS_LO) && res_o.read_position <= RD_POS_W'(POS_HI)))
    else $error("decoded position out of range");

endmodule

[bench/mcc_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_frame_checker: result checker for the motor command codec
// Watches the request, result and register-write ports, keeps its own copy of
// the command codes and registers, works out the frames and readings each
// accepted request must produce, and compares every accepted result with the
// oldest one still owed.
// ----------------------------------------------------------------------------
module mcc_frame_checker import mcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mcc_cmd_if                    cmd,
  mcc_res_if                    res,
  output int                    fail_count,
  output int                    outputs_due
);

  logic [7:0]               motor_id_q;
  logic                     powered_q;
  logic [POSITION_BITS-1:0] pos_code;
  logic [FIELD_BITS-1:0]    vel_code;
  logic [FIELD_BITS-1:0]    kp_code;
  logic [FIELD_BITS-1:0]    kd_code;
  logic [FIELD_BITS-1:0]    tor_code;
  mcc_res_t                 owed_q[$];
  int                       mismatches;

  // Look up the Q16.16 range and the full-scale code of a field
  function automatic void field_range(input logic [2:0] f, output longint lo,
                                      output longint hi, output longint full);
    case (f)
      FLD_POS: begin
        lo = POS_LO;
        hi = POS_HI;
      end
      FLD_VEL: begin
        lo = VEL_LO;
        hi = VEL_HI;
      end
      FLD_KP: begin
        lo = KP_LO;
        hi = KP_HI;
      end
      FLD_KD: begin
        lo = KD_LO;
        hi = KD_HI;
      end
      default: begin
        lo = TOR_LO;
        hi = TOR_HI;
      end
    endcase
    full = (f == FLD_POS) ? POS_D : FLD_D;
  endfunction

  // Clamp a Q16.16 value to its field and scale it down to a code
  function automatic longint scale_to_code(input logic [2:0] f,
                                           input logic signed [31:0] x);
    longint lo, hi, full, xv;
    field_range(f, lo, hi, full);
    xv = x;
    if (xv < lo) xv = lo;
    if (xv > hi) xv = hi;
    return ((xv - lo) * full) / (hi - lo);
  endfunction

  // Expand a code back to Q16.16, rounding half up
  function automatic longint code_to_reading(input logic [2:0] f, input longint code);
    longint lo, hi, full;
    field_range(f, lo, hi, full);
    return (code * (hi - lo) + full / 2) / full + lo;
  endfunction

  function automatic void set_command(input logic [2:0] f, input longint code);
    case (f)
      FLD_POS: pos_code = POSITION_BITS'(code);
      FLD_VEL: vel_code = FIELD_BITS'(code);
      FLD_KP:  kp_code  = FIELD_BITS'(code);
      FLD_KD:  kd_code  = FIELD_BITS'(code);
      default: tor_code = FIELD_BITS'(code);
    endcase
  endfunction

  // Return every command to the code of 0.0
  function automatic void clear_commands();
    for (int i = 0; i <= FLD_TOR; i++) begin
      set_command(3'(i), scale_to_code(3'(i), 0));
    end
  endfunction

  function automatic mcc_res_t frame_out(input res_kind_e k, input logic [63:0] bytes,
                                         input logic last_flag);
    mcc_res_t r;
    r = '0;
    r.result_kind = k;
    r.frame_id    = motor_id_q;
    r.frame_bytes = bytes;
    r.last        = last_flag;
    return r;
  endfunction

  // Work out what one accepted request owes
  function automatic void predict_request();
    mcc_res_t r;
    case (cmd.kind)
      KIND_SET: begin
        if (cmd.field_index <= FLD_TOR)
          set_command(cmd.field_index, scale_to_code(cmd.field_index, cmd.value));
      end
      KIND_SEND: begin
        if (powered_q) begin
          pos_code = POSITION_BITS'(scale_to_code(FLD_POS, cmd.value));
          owed_q.push_back(frame_out(RES_CMD,
                                     {pos_code, vel_code, kp_code, kd_code, tor_code}, 1'b1));
        end
      end
      KIND_MODE: begin
        if (cmd.mode_code <= MODE_ZERO) begin
          // Zero mode clears the commands and, when powered, sends them ahead of the mode frame
          if (cmd.mode_code == MODE_ZERO) begin
            clear_commands();
            if (powered_q)
              owed_q.push_back(frame_out(RES_CMD,
                                         {pos_code, vel_code, kp_code, kd_code, tor_code},
                                         1'b0));
          end
          owed_q.push_back(frame_out(RES_MODE,
                                     {{7{FILL_BYTE}}, MODE_BYTE_BASE + 8'(cmd.mode_code)},
                                     1'b1));
        end
      end
      default: begin
        r = '0;
        r.result_kind   = RES_READ;
        r.read_position = RD_POS_W'(code_to_reading(FLD_POS, cmd.reply_bytes[39:24]));
        r.read_velocity = RD_VEL_W'(code_to_reading(FLD_VEL, cmd.reply_bytes[23:12]));
        r.read_torque   = RD_TOR_W'(code_to_reading(FLD_TOR, cmd.reply_bytes[11:0]));
        r.last          = 1'b1;
        owed_q.push_back(r);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one accepted result with the oldest owed one
  function automatic void check_result();
    mcc_res_t want;
    if (owed_q.size() == 0) begin
      $error("result with nothing owed: result_kind %0d", res.result_kind);
      mismatches++;
    end else begin
      want = owed_q.pop_front();
      check_field("result_kind",   want.result_kind,   res.result_kind);
      check_field("frame_id",      want.frame_id,      res.frame_id);
      check_field("frame_bytes",   want.frame_bytes,   res.frame_bytes);
      check_field("read_position", want.read_position, res.read_position);
      check_field("read_velocity", want.read_velocity, res.read_velocity);
      check_field("read_torque",   want.read_torque,   res.read_torque);
      check_field("last",          want.last,          res.last);
    end
  endfunction

  // Track requests, results and register writes at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q = '0;
      powered_q  = 1'b0;
      clear_commands();
      owed_q.delete();
      mismatches = 0;
      fail_count  <= 0;
      outputs_due <= 0;
    end else begin
      if (res.valid && res.ready) check_result();
      if (cmd.valid && cmd.ready) predict_request();
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MOTOR_ID: motor_id_q = cfg_wdata_i;
          CFG_POWERED:  powered_q  = cfg_wdata_i[0];
          default: ;
        endcase
      end
      fail_count  <= mismatches;
      outputs_due <= owed_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the motor command codec
// Drives directed and random command, mode and reply requests through the
// codec under several motor id and power settings, with random idling on both
// channels and one long result back-pressure stretch; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import mcc_pkg::*;

  localparam int     CLK_PERIOD     = 12;
  localparam int     SETTLE_CYCLES  = 12;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     PHASES         = 8;
  localparam int     PHASE_REQS     = 212;
  localparam longint TIMEOUT_CYCLES = 250000;

  localparam logic [2:0] FLD_UNUSED_MIN = 3'd5;
  localparam logic [2:0] FLD_UNUSED_MAX = 3'd7;
  localparam logic [1:0] MODE_UNKNOWN   = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    outputs_due;
  int                    tx_idle_pct = 37;
  int                    rx_idle_pct = 37;
  bit                    hold_off_req = 1'b0;

  mcc_cmd_if cmd_bus ();
  mcc_res_if res_bus ();

  motor_can_command_codec uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_bus),
    .res_o       (res_bus)
  );

  mcc_frame_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .cmd         (cmd_bus),
    .res         (res_bus),
    .fail_count  (fail_count),
    .outputs_due (outputs_due)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Offer one request, idling first at random, and hold it until accepted
  task automatic offer_request(input kind_e k, input logic [2:0] f,
                               input logic signed [31:0] v, input logic [1:0] m,
                               input logic [39:0] rb);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.kind        <= k;
    cmd_bus.field_index <= f;
    cmd_bus.value       <= v;
    cmd_bus.mode_code   <= m;
    cmd_bus.reply_bytes <= rb;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  // Pick a value in range, on a bound or zero, just outside, or anywhere
  function automatic logic signed [31:0] rand_value(input logic [2:0] f);
    logic signed [31:0] lo, hi;
    lo = field_lo(f);
    hi = field_hi(f);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return lo + $urandom_range(hi - lo);
      5: begin
        case ($urandom_range(2))
          0:       return lo;
          1:       return hi;
          default: return 0;
        endcase
      end
      6:       return lo - $urandom_range(1, 4096);
      7:       return hi + $urandom_range(1, 4096);
      default: return $urandom();
    endcase
  endfunction

  // Mostly valid fields and modes, some unknown ones as noise
  task automatic random_request();
    logic [2:0]  f;
    logic [1:0]  m;
    logic [39:0] rb;
    int          pick;
    pick = $urandom_range(99);
    f  = ($urandom_range(9) == 0) ? 3'($urandom_range(FLD_UNUSED_MIN, FLD_UNUSED_MAX))
                                  : 3'($urandom_range(FLD_TOR));
    m  = ($urandom_range(11) == 0) ? MODE_UNKNOWN : 2'($urandom_range(MODE_ZERO));
    rb = 40'({$urandom(), $urandom()});
    if (pick < 30)
      offer_request(KIND_SET, f, rand_value(f), 2'($urandom()), rb);
    else if (pick < 55)
      offer_request(KIND_SEND, 3'($urandom()), rand_value(FLD_POS), 2'($urandom()), rb);
    else if (pick < 70)
      offer_request(KIND_MODE, 3'($urandom()), $urandom(), m, rb);
    else
      offer_request(KIND_REPLY, 3'($urandom()), $urandom(), 2'($urandom()), rb);
  endtask

  // Drop valid and wait until every owed result has come, then let the pipe empty
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (outputs_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] id, input logic pwr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MOTOR_ID;
    cfg_wdata <= id;
    @(posedge clk_i);
    cfg_index <= CFG_POWERED;
    cfg_wdata <= CFG_DATA_W'(pwr);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [7:0] id;
    logic       pwr;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.kind        <= KIND_SET;
    cmd_bus.field_index <= FLD_POS;
    cmd_bus.value       <= '0;
    cmd_bus.mode_code   <= MODE_ENTER;
    cmd_bus.reply_bytes <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_MOTOR_ID;
    cfg_wdata           <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Powered: bounds, clamping, ignored fields, every mode, reply extremes
    configure(8'hA5, 1'b1);
    offer_request(KIND_SEND, FLD_POS, 0, MODE_ENTER, '0);
    offer_request(KIND_SET, FLD_POS, 32'sh7FFFFFFF, MODE_ENTER, '0);
    offer_request(KIND_SET, FLD_VEL, 32'sh80000000, MODE_ENTER, '0);
    offer_request(KIND_SET, FLD_KP, KP_HI, MODE_ENTER, '0);
    offer_request(KIND_SET, FLD_KD, -1, MODE_ENTER, '0);
    offer_request(KIND_SET, FLD_TOR, TOR_HI + 1, MODE_ENTER, '0);
    offer_request(KIND_SET, FLD_UNUSED_MIN, 0, MODE_ENTER, '0);
    offer_request(KIND_SET, FLD_UNUSED_MAX, 32'sh7FFFFFFF, MODE_ENTER, '0);
    offer_request(KIND_SEND, FLD_POS, POS_LO, MODE_ENTER, '0);
    offer_request(KIND_SEND, FLD_POS, POS_HI, MODE_ENTER, '0);
    offer_request(KIND_MODE, FLD_POS, 0, MODE_ENTER, '0);
    offer_request(KIND_MODE, FLD_POS, 0, MODE_EXIT, '0);
    offer_request(KIND_MODE, FLD_POS, 0, MODE_UNKNOWN, '0);
    offer_request(KIND_MODE, FLD_POS, 0, MODE_ZERO, '0);
    offer_request(KIND_SEND, FLD_POS, 0, MODE_ENTER, '0);
    offer_request(KIND_REPLY, FLD_POS, 0, MODE_ENTER, '0);
    offer_request(KIND_REPLY, FLD_POS, 0, MODE_ENTER, '1);
    offer_request(KIND_REPLY, FLD_POS, 0, MODE_ENTER, {16'h7FFF, 12'h7FF, 12'h7FF});
    offer_request(KIND_REPLY, FLD_POS, 0, MODE_ENTER, 40'({$urandom(), $urandom()}));
    settle();

    // Unpowered: sends are dropped, zero mode gives only the mode frame
    configure(8'h00, 1'b0);
    offer_request(KIND_SEND, FLD_POS, POS_HI, MODE_ENTER, '0);
    offer_request(KIND_MODE, FLD_POS, 0, MODE_ZERO, '0);
    offer_request(KIND_SET, FLD_KP, 12345, MODE_ENTER, '0);
    offer_request(KIND_MODE, FLD_POS, 0, MODE_ENTER, '0);
    offer_request(KIND_REPLY, FLD_POS, 0, MODE_ENTER, 40'({$urandom(), $urandom()}));
    settle();

    // Random phases over several register settings and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      id  = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom());
      pwr = (p == 2 || p == 5) ? 1'b0 : 1'b1;
      configure(id, pwr);
      tx_idle_pct = (p == 1 || p == 3) ? 0 : 37;
      rx_idle_pct = (p == 1) ? 0 : 37;
      if (p == 3) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_REQS; n++) random_request();
      settle();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule
